// ===== rtl/top_k_three_list_sums_defines.svh =====
// Assertion macros used by the checker file of top_k_three_list_sums.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TOP_K_THREE_LIST_SUMS_DEFINES_SVH
`define TOP_K_THREE_LIST_SUMS_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define TKLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkls check failed");

// next-cycle implication, disabled while reset is held
`define TKLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkls check failed");

`endif

// ===== rtl/tkls_pkg.sv =====
// Package for top_k_three_list_sums: sizes, codes, heap entry type and the
// heap ordering function. No dependencies.
`timescale 1ns / 1ps
package tkls_pkg;

  localparam int LIST_DEPTH = 1024;
  localparam int HEAP_DEPTH = 4096;
  localparam int VIS_DEPTH  = 4096;
  localparam int VALUE_BITS = 40;

  localparam int SUM_BITS = VALUE_BITS + 2;
  localparam int LIST_AW  = $clog2(LIST_DEPTH);
  localparam int LIST_CW  = LIST_AW + 1;
  localparam int HEAP_AW  = $clog2(HEAP_DEPTH);
  localparam int HEAP_CW  = HEAP_AW + 1;
  localparam int VIS_AW   = $clog2(VIS_DEPTH);
  localparam int VIS_CW   = VIS_AW + 1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_EXH = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [LIST_AW-1:0] ia;
    logic [LIST_AW-1:0] ib;
    logic [LIST_AW-1:0] ic;
  } trip_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    trip_t               idx;
  } heap_ent_t;

  // x leaves the heap before y: larger sum, then smaller index triple
  function automatic logic ranks_above(heap_ent_t x, heap_ent_t y);
    logic res;
    if (x.sum != y.sum) res = (x.sum > y.sum);
    else                res = (x.idx < y.idx);
    return res;
  endfunction

endpackage

// ===== rtl/tkls_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
module tkls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rq
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq <= mem[ra];
  end

endmodule

// ===== rtl/top_k_three_list_sums.sv =====
// Enumerates a[i]+b[j]+c[k] in descending order from three sorted lists, one
// word in, at most one word out. A load reads and shifts each smaller list
// entry up by one until the slot for the new value is found; a load to a
// full list or with an unused selector drops the word. A next accepts the
// word, seeds the heap first if it is not yet seeded, reads the heap top and,
// if others remain, the last entry, sifts down, checks the three successors
// and writes the result; each successor that lies inside the lists starts a
// linear search of the visited memory and, when new, is added to the heap
// with a sift-up: the visited search dominates once many sums have been drawn.
// Lists, heap and visited set live in single-read-port memories, one access
// per cycle each. Results wait in an output register; a new word is taken
// while it waits.
`timescale 1ns / 1ps
module top_k_three_list_sums (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[39:0]
  input  logic [3:0]  in_tuser,   // op[1:0], list_select[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // sum[41:0], index_a[51:42], index_b[61:52], index_c[71:62]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int LAW = tkls_pkg::LIST_AW;
  localparam int LCW = tkls_pkg::LIST_CW;
  localparam int HAW = tkls_pkg::HEAP_AW;
  localparam int HCW = tkls_pkg::HEAP_CW;
  localparam int VAW = tkls_pkg::VIS_AW;
  localparam int VCW = tkls_pkg::VIS_CW;
  localparam int VB  = tkls_pkg::VALUE_BITS;
  localparam int SB  = tkls_pkg::SUM_BITS;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LD_RD    = 5'd1;
  localparam logic [4:0] S_LD_WR    = 5'd2;
  localparam logic [4:0] S_SEED_RD  = 5'd3;
  localparam logic [4:0] S_SEED_SUM = 5'd4;
  localparam logic [4:0] S_POP_RD   = 5'd5;
  localparam logic [4:0] S_POP_TOP  = 5'd6;
  localparam logic [4:0] S_POP_LAST = 5'd7;
  localparam logic [4:0] S_DN_RDL   = 5'd8;
  localparam logic [4:0] S_DN_RDR   = 5'd9;
  localparam logic [4:0] S_DN_CMP   = 5'd10;
  localparam logic [4:0] S_OFF_CHK  = 5'd11;
  localparam logic [4:0] S_VIS      = 5'd12;
  localparam logic [4:0] S_OFF_ADD  = 5'd13;
  localparam logic [4:0] S_OFF_SUM  = 5'd14;
  localparam logic [4:0] S_UP_RD    = 5'd15;
  localparam logic [4:0] S_UP_CMP   = 5'd16;
  localparam logic [4:0] S_OUT      = 5'd17;

  // control state
  logic [4:0]     state_r, state_nxt;
  logic [LCW-1:0] cnt_r [3];
  logic [LCW-1:0] cnt_nxt [3];
  logic           seeded_r, seeded_nxt;
  logic [HCW-1:0] heap_cnt_r, heap_cnt_nxt;
  logic [VCW-1:0] vis_cnt_r, vis_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  // working registers
  logic [1:0]           sel_r, sel_nxt;
  logic [VB-1:0]        val_r, val_nxt;
  logic [LCW-1:0]       j_r, j_nxt;
  tkls_pkg::heap_ent_t  top_r, top_nxt;
  tkls_pkg::heap_ent_t  x_r, x_nxt;
  tkls_pkg::heap_ent_t  ch_r, ch_nxt;
  logic                 lab_r, lab_nxt;
  logic                 has_r_r, has_r_nxt;
  logic [HAW-1:0]       hole_r, hole_nxt;
  logic [1:0]           k_r, k_nxt;
  tkls_pkg::trip_t      cand_r, cand_nxt;
  logic [VCW-1:0]       vis_i_r, vis_i_nxt;
  logic                 vpend_r, vpend_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [71:0]          out_data_r, out_data_nxt;
  logic [1:0]           out_st_r, out_st_nxt;

  // memory ports
  logic [2:0]     l_we;
  logic [LAW-1:0] l_wa;
  logic [VB-1:0]  l_wd;
  logic [LAW-1:0] l_ra [3];
  logic [VB-1:0]  l_q [3];

  logic                h_we;
  logic [HAW-1:0]      h_wa, h_ra;
  tkls_pkg::heap_ent_t h_wd, h_q;

  logic                v_we;
  logic [VAW-1:0]      v_wa, v_ra;
  tkls_pkg::trip_t     v_wd, v_q;

  // helpers
  logic [1:0]          in_op, in_sel;
  logic [LCW-1:0]      in_cnt, sel_cnt;
  logic [VB-1:0]       sel_q;
  logic [HAW+1:0]      dn_l, dn_r, cnt_ext;
  logic [HAW-1:0]      up_par;
  logic [LCW-1:0]      off_a, off_b, off_c;
  logic [SB-1:0]       sum3;
  tkls_pkg::heap_ent_t dn_best;
  logic                adv, ld_fin;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_list
      tkls_ram #(.WIDTH(VB), .DEPTH(tkls_pkg::LIST_DEPTH)) u_list (
        .clk (clk),
        .we  (l_we[g]),
        .wa  (l_wa),
        .wd  (l_wd),
        .ra  (l_ra[g]),
        .rq  (l_q[g])
      );
    end
  endgenerate

  tkls_ram #(.WIDTH($bits(tkls_pkg::heap_ent_t)), .DEPTH(tkls_pkg::HEAP_DEPTH)) u_heap (
    .clk (clk),
    .we  (h_we),
    .wa  (h_wa),
    .wd  (h_wd),
    .ra  (h_ra),
    .rq  (h_q)
  );

  tkls_ram #(.WIDTH($bits(tkls_pkg::trip_t)), .DEPTH(tkls_pkg::VIS_DEPTH)) u_vis (
    .clk (clk),
    .we  (v_we),
    .wa  (v_wa),
    .wd  (v_wd),
    .ra  (v_ra),
    .rq  (v_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  assign in_op  = in_tuser[1:0];
  assign in_sel = in_tuser[3:2];

  always_comb begin
    case (in_sel)
      tkls_pkg::SEL_A: in_cnt = cnt_r[0];
      tkls_pkg::SEL_B: in_cnt = cnt_r[1];
      tkls_pkg::SEL_C: in_cnt = cnt_r[2];
      default:         in_cnt = LCW'(tkls_pkg::LIST_DEPTH);
    endcase
    case (sel_r)
      tkls_pkg::SEL_A: begin sel_cnt = cnt_r[0]; sel_q = l_q[0]; end
      tkls_pkg::SEL_B: begin sel_cnt = cnt_r[1]; sel_q = l_q[1]; end
      default:         begin sel_cnt = cnt_r[2]; sel_q = l_q[2]; end
    endcase
  end

  assign dn_l    = {1'b0, hole_r, 1'b1};
  assign dn_r    = {1'b0, hole_r, 1'b0} + (HAW+2)'(2);
  assign cnt_ext = {1'b0, heap_cnt_r};
  assign up_par  = (hole_r - HAW'(1)) >> 1;
  assign off_a   = {1'b0, top_r.idx.ia} + LCW'(k_r == 2'd0);
  assign off_b   = {1'b0, top_r.idx.ib} + LCW'(k_r == 2'd1);
  assign off_c   = {1'b0, top_r.idx.ic} + LCW'(k_r == 2'd2);
  assign sum3    = SB'(l_q[0]) + SB'(l_q[1]) + SB'(l_q[2]);
  assign dn_best = lab_r ? ch_r : x_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seeded_nxt    = seeded_r;
    heap_cnt_nxt  = heap_cnt_r;
    vis_cnt_nxt   = vis_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sel_nxt       = sel_r;
    val_nxt       = val_r;
    j_nxt         = j_r;
    top_nxt       = top_r;
    x_nxt         = x_r;
    ch_nxt        = ch_r;
    lab_nxt       = lab_r;
    has_r_nxt     = has_r_r;
    hole_nxt      = hole_r;
    k_nxt         = k_r;
    cand_nxt      = cand_r;
    vis_i_nxt     = vis_i_r;
    vpend_nxt     = vpend_r;
    st_nxt        = st_r;
    out_data_nxt  = out_data_r;
    out_st_nxt    = out_st_r;
    l_we          = 3'b000;
    l_wa          = '0;
    l_wd          = val_r;
    l_ra[0]       = '0;
    l_ra[1]       = '0;
    l_ra[2]       = '0;
    h_we          = 1'b0;
    h_wa          = hole_r;
    h_wd          = x_r;
    h_ra          = '0;
    v_we          = 1'b0;
    v_wa          = vis_cnt_r[VAW-1:0];
    v_wd          = cand_r;
    v_ra          = vis_i_r[VAW-1:0];
    adv           = 1'b0;
    ld_fin        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            tkls_pkg::OP_LOAD: begin
              // a full list or an unused selector drops the word
              if (in_cnt != LCW'(tkls_pkg::LIST_DEPTH)) begin
                sel_nxt   = in_sel;
                val_nxt   = in_tdata[VB-1:0];
                j_nxt     = in_cnt;
                state_nxt = S_LD_RD;
              end
            end
            tkls_pkg::OP_NEXT: begin
              st_nxt = tkls_pkg::ST_OK;
              if (!seeded_r && cnt_r[0] != '0 && cnt_r[1] != '0 && cnt_r[2] != '0) begin
                state_nxt = S_SEED_RD;
              end else if (heap_cnt_r == '0) begin
                top_nxt   = '0;
                st_nxt    = tkls_pkg::ST_EXH;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            tkls_pkg::OP_CLEAR: begin
              cnt_nxt[0]   = '0;
              cnt_nxt[1]   = '0;
              cnt_nxt[2]   = '0;
              heap_cnt_nxt = '0;
              vis_cnt_nxt  = '0;
              seeded_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // shift smaller entries up by one until the slot for the new value
      S_LD_RD: begin
        if (j_r == '0) begin
          l_we[sel_r] = 1'b1;
          l_wa        = '0;
          ld_fin      = 1'b1;
        end else begin
          l_ra[0]   = LAW'(j_r - LCW'(1));
          l_ra[1]   = LAW'(j_r - LCW'(1));
          l_ra[2]   = LAW'(j_r - LCW'(1));
          state_nxt = S_LD_WR;
        end
      end

      S_LD_WR: begin
        l_we[sel_r] = 1'b1;
        l_wa        = j_r[LAW-1:0];
        if (sel_q < val_r) begin
          l_wd      = sel_q;
          j_nxt     = j_r - LCW'(1);
          state_nxt = S_LD_RD;
        end else begin
          ld_fin = 1'b1;
        end
      end

      S_SEED_RD: begin
        state_nxt = S_SEED_SUM;
      end

      S_SEED_SUM: begin
        h_we         = 1'b1;
        h_wa         = '0;
        h_wd         = '{sum: sum3, idx: '0};
        heap_cnt_nxt = HCW'(1);
        seeded_nxt   = 1'b1;
        state_nxt    = S_POP_RD;
      end

      S_POP_RD: begin
        h_ra      = '0;
        state_nxt = S_POP_TOP;
      end

      S_POP_TOP: begin
        top_nxt      = h_q;
        heap_cnt_nxt = heap_cnt_r - HCW'(1);
        if (heap_cnt_r == HCW'(1)) begin
          k_nxt     = 2'd0;
          state_nxt = S_OFF_CHK;
        end else begin
          h_ra      = HAW'(heap_cnt_r - HCW'(1));
          state_nxt = S_POP_LAST;
        end
      end

      S_POP_LAST: begin
        x_nxt     = h_q;
        hole_nxt  = '0;
        state_nxt = S_DN_RDL;
      end

      S_DN_RDL: begin
        if (dn_l >= cnt_ext) begin
          h_we      = 1'b1;
          k_nxt     = 2'd0;
          state_nxt = S_OFF_CHK;
        end else begin
          h_ra      = dn_l[HAW-1:0];
          state_nxt = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        ch_nxt    = h_q;
        lab_nxt   = tkls_pkg::ranks_above(h_q, x_r);
        has_r_nxt = (dn_r < cnt_ext);
        h_ra      = dn_r[HAW-1:0];
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        h_we = 1'b1;
        if (has_r_r && tkls_pkg::ranks_above(h_q, dn_best)) begin
          h_wd      = h_q;
          hole_nxt  = dn_r[HAW-1:0];
          state_nxt = S_DN_RDL;
        end else if (lab_r) begin
          h_wd      = ch_r;
          hole_nxt  = dn_l[HAW-1:0];
          state_nxt = S_DN_RDL;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_OFF_CHK;
        end
      end

      S_OFF_CHK: begin
        if (off_a < cnt_r[0] && off_b < cnt_r[1] && off_c < cnt_r[2]) begin
          cand_nxt  = '{ia: off_a[LAW-1:0], ib: off_b[LAW-1:0], ic: off_c[LAW-1:0]};
          vis_i_nxt = '0;
          vpend_nxt = 1'b0;
          state_nxt = S_VIS;
        end else begin
          adv = 1'b1;
        end
      end

      // one visited entry read per cycle, compared the cycle after
      S_VIS: begin
        if (vpend_r && v_q == cand_r) begin
          vpend_nxt = 1'b0;
          adv       = 1'b1;
        end else if (vis_i_r < vis_cnt_r) begin
          vis_i_nxt = vis_i_r + VCW'(1);
          vpend_nxt = 1'b1;
        end else begin
          vpend_nxt = 1'b0;
          state_nxt = S_OFF_ADD;
        end
      end

      S_OFF_ADD: begin
        if (heap_cnt_r == HCW'(tkls_pkg::HEAP_DEPTH) ||
            vis_cnt_r == VCW'(tkls_pkg::VIS_DEPTH)) begin
          st_nxt = tkls_pkg::ST_OVF;
          adv    = 1'b1;
        end else begin
          l_ra[0]   = cand_r.ia;
          l_ra[1]   = cand_r.ib;
          l_ra[2]   = cand_r.ic;
          state_nxt = S_OFF_SUM;
        end
      end

      S_OFF_SUM: begin
        x_nxt        = '{sum: sum3, idx: cand_r};
        v_we         = 1'b1;
        vis_cnt_nxt  = vis_cnt_r + VCW'(1);
        hole_nxt     = heap_cnt_r[HAW-1:0];
        heap_cnt_nxt = heap_cnt_r + HCW'(1);
        state_nxt    = S_UP_RD;
      end

      S_UP_RD: begin
        if (hole_r == '0) begin
          h_we = 1'b1;
          adv  = 1'b1;
        end else begin
          h_ra      = up_par;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        h_we = 1'b1;
        if (tkls_pkg::ranks_above(x_r, h_q)) begin
          h_wd      = h_q;
          hole_nxt  = up_par;
          state_nxt = S_UP_RD;
        end else begin
          adv = 1'b1;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {top_r.idx.ic, top_r.idx.ib, top_r.idx.ia, top_r.sum};
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // finished load: bump the count and restart the enumeration
    if (ld_fin) begin
      case (sel_r)
        tkls_pkg::SEL_A: cnt_nxt[0] = sel_cnt + LCW'(1);
        tkls_pkg::SEL_B: cnt_nxt[1] = sel_cnt + LCW'(1);
        default:         cnt_nxt[2] = sel_cnt + LCW'(1);
      endcase
      heap_cnt_nxt = '0;
      vis_cnt_nxt  = '0;
      seeded_nxt   = 1'b0;
      state_nxt    = S_IDLE;
    end

    // advance to the next successor, or to the result after the third
    if (adv) begin
      if (k_r == 2'd2) begin
        state_nxt = S_OUT;
      end else begin
        k_nxt     = k_r + 2'd1;
        state_nxt = S_OFF_CHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      cnt_r[2]    <= '0;
      seeded_r    <= 1'b0;
      heap_cnt_r  <= '0;
      vis_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      vpend_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seeded_r    <= seeded_nxt;
      heap_cnt_r  <= heap_cnt_nxt;
      vis_cnt_r   <= vis_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      vpend_r     <= vpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    val_r      <= val_nxt;
    j_r        <= j_nxt;
    top_r      <= top_nxt;
    x_r        <= x_nxt;
    ch_r       <= ch_nxt;
    lab_r      <= lab_nxt;
    has_r_r    <= has_r_nxt;
    hole_r     <= hole_nxt;
    k_r        <= k_nxt;
    cand_r     <= cand_nxt;
    vis_i_r    <= vis_i_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
  end

endmodule

// ===== rtl/tkls_checker.sv =====
// Port-level checks for top_k_three_list_sums, bound to the top level.
// Depends on tkls_pkg and top_k_three_list_sums_defines.svh.
`timescale 1ns / 1ps
`include "top_k_three_list_sums_defines.svh"
module tkls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result word holds
  `TKLS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // an exhausted result carries no sum and no indexes
  `TKLS_ASSERT_IMP(a_exh_zero, out_tvalid && out_tuser == tkls_pkg::ST_EXH, out_tdata == '0)

  // status is ok, exhausted or overflow
  `TKLS_ASSERT_IMP(a_status, out_tvalid, out_tuser == tkls_pkg::ST_OK || out_tuser == tkls_pkg::ST_EXH || out_tuser == tkls_pkg::ST_OVF)

endmodule

bind top_k_three_list_sums tkls_checker u_tkls_checker (.*);
